// ===== hw/rtl/gfm_pkg.sv =====
package gfm_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = 13;
    localparam int POS_W      = $clog2(MAX_DIM);
    localparam int DIST_W     = 2 * POS_W + 1;
    localparam int R2_W       = 2 * DIM_W;

    localparam int WFRAC      = 16;
    localparam int WEIGHT_W   = WFRAC + 1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = {1'b1, {WFRAC{1'b0}}};

    // distance ratio: integer part selects the exp table range, fraction feeds the series
    localparam int RATIO_FRAC = 16;
    localparam int INT_BITS   = 5;
    localparam int QUO_W      = INT_BITS + RATIO_FRAC;

    // q30 arithmetic of the exponent
    localparam int QF         = 30;
    localparam int QV_W       = QF + 1;
    localparam logic [QV_W-1:0] Q_ONE = {1'b1, {QF{1'b0}}};
    localparam int TERMS      = 16;
    localparam int K_W        = 5;
    localparam int RCP_W      = 32;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_FRAME_ROWS = 2'd0,
        CFG_FRAME_COLS = 2'd1,
        CFG_RADIUS     = 2'd2,
        CFG_PASS_MODE  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [DIST_W-1:0] dist2;
        logic              last;
        logic              err;
    } desc_t;

    // floor(2^31 / k) for the series divisors
    function automatic logic [RCP_W-1:0] recip(input logic [K_W-1:0] k);
        logic [RCP_W-1:0] r;
        unique case (k)
            5'd1:    r = 32'd2147483648;
            5'd2:    r = 32'd1073741824;
            5'd3:    r = 32'd715827882;
            5'd4:    r = 32'd536870912;
            5'd5:    r = 32'd429496729;
            5'd6:    r = 32'd357913941;
            5'd7:    r = 32'd306783378;
            5'd8:    r = 32'd268435456;
            5'd9:    r = 32'd238609294;
            5'd10:   r = 32'd214748364;
            5'd11:   r = 32'd195225786;
            5'd12:   r = 32'd178956970;
            5'd13:   r = 32'd165191049;
            5'd14:   r = 32'd153391689;
            5'd15:   r = 32'd143165576;
            5'd16:   r = 32'd134217728;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v < DIM_W'(2))
            r = DIM_W'(2);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== hw/rtl/gfm_front.sv =====
module gfm_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic                      frame_start,
    input  logic [gfm_pkg::DIM_W-1:0] frame_rows,
    input  logic [gfm_pkg::DIM_W-1:0] frame_cols,
    input  logic [gfm_pkg::DIM_W-1:0] radius,
    output gfm_pkg::desc_t            desc
);

    localparam int POS_W = gfm_pkg::POS_W;
    localparam int DIM_W = gfm_pkg::DIM_W;
    localparam int SQ_W  = 2 * POS_W;

    logic [POS_W-1:0] row_reg, row_next;
    logic [POS_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] rows, cols, rows_m1, cols_m1;
    logic [POS_W-1:0] row_cur, col_cur, cr, cc, dr, dc;
    logic [SQ_W-1:0]  dr2, dc2;

    always_comb
    begin
        rows    = gfm_pkg::clamp_dim(frame_rows);
        cols    = gfm_pkg::clamp_dim(frame_cols);
        rows_m1 = rows - DIM_W'(1);
        cols_m1 = cols - DIM_W'(1);
        row_cur = frame_start ? '0 : row_reg;
        col_cur = frame_start ? '0 : col_reg;
        cr      = POS_W'(rows >> 1);
        cc      = POS_W'(cols >> 1);
        dr      = (row_cur >= cr) ? (row_cur - cr) : (cr - row_cur);
        dc      = (col_cur >= cc) ? (col_cur - cc) : (cc - col_cur);
        dr2     = SQ_W'(dr) * SQ_W'(dr);
        dc2     = SQ_W'(dc) * SQ_W'(dc);

        desc.dist2 = gfm_pkg::DIST_W'(dr2) + gfm_pkg::DIST_W'(dc2);
        desc.err   = (radius == '0) || (radius > rows) || (radius >= cols);
        desc.last  = (DIM_W'(row_cur) == rows_m1) && (DIM_W'(col_cur) == cols_m1);

        // raster walk, wraps early when the frame shrank under the counters
        if (DIM_W'(col_cur) >= cols_m1)
        begin
            col_next = '0;
            row_next = (DIM_W'(row_cur) >= rows_m1) ? '0 : row_cur + POS_W'(1);
        end
        else
        begin
            col_next = col_cur + POS_W'(1);
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

// ===== hw/rtl/gfm_fifo.sv =====
module gfm_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              pop,
    output logic [DATA_W-1:0] rd_data,
    output logic              full,
    output logic              empty
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

// ===== hw/rtl/gfm_div.sv =====
module gfm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [gfm_pkg::DIST_W-1:0] dividend,
    input  logic [gfm_pkg::R2_W-1:0]   divisor,
    output logic                       done,
    output logic                       overflow,
    output logic [gfm_pkg::QUO_W-1:0]  quotient
);

    localparam int QUO_W  = gfm_pkg::QUO_W;
    localparam int R2_W   = gfm_pkg::R2_W;
    localparam int IB     = gfm_pkg::INT_BITS;
    localparam int CNT_W  = $clog2(QUO_W + 1);
    localparam int CMP_W  = R2_W + IB;

    logic              busy_reg, done_reg, ovf_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [R2_W-1:0]   rem_reg, den_reg;
    logic [QUO_W-1:0]  bits_reg, quo_reg;
    logic [R2_W:0]     trial;
    logic              qbit;
    logic              big;

    assign done     = done_reg;
    assign overflow = ovf_reg;
    assign quotient = quo_reg;

    // a ratio of 2^IB or more lies beyond the exp table
    assign big   = (CMP_W'(dividend) >= (CMP_W'(divisor) << IB));
    assign trial = {rem_reg, bits_reg[QUO_W-1]};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            bits_reg <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                den_reg  <= divisor;
                ovf_reg  <= big;
                rem_reg  <= R2_W'(dividend >> IB);
                bits_reg <= {dividend[IB-1:0], {gfm_pkg::RATIO_FRAC{1'b0}}};
                quo_reg  <= '0;
                cnt_reg  <= CNT_W'(QUO_W);
                busy_reg <= !big;
                done_reg <= big;
            end
            else if (busy_reg)
            begin
                rem_reg  <= qbit ? R2_W'(trial - {1'b0, den_reg}) : R2_W'(trial);
                quo_reg  <= {quo_reg[QUO_W-2:0], qbit};
                bits_reg <= bits_reg << 1;
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/gfm_back.sv =====
module gfm_back #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  logic [SAMPLE_WIDTH-1:0]      q_real,
    input  logic [SAMPLE_WIDTH-1:0]      q_imag,
    input  gfm_pkg::desc_t               q_desc,
    output logic                         q_pop,
    input  logic [gfm_pkg::DIM_W-1:0]    radius,
    input  logic                         pass_mode,
    output logic                         div_start,
    output logic [gfm_pkg::R2_W-1:0]     div_den,
    input  logic                         div_done,
    input  logic                         div_ovf,
    input  logic [gfm_pkg::QUO_W-1:0]    div_quo,
    input  logic                         out_take,
    output logic                         out_valid,
    output logic [SAMPLE_WIDTH-1:0]      real_out,
    output logic [SAMPLE_WIDTH-1:0]      imag_out,
    output logic [gfm_pkg::WEIGHT_W-1:0] weight_out,
    output logic                         last_out,
    output logic                         err_out
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int QF     = gfm_pkg::QF;
    localparam int QV_W   = gfm_pkg::QV_W;
    localparam int K_W    = gfm_pkg::K_W;
    localparam int WW     = gfm_pkg::WEIGHT_W;
    localparam int WFRAC  = gfm_pkg::WFRAC;
    localparam int RF     = gfm_pkg::RATIO_FRAC;
    localparam int IB     = gfm_pkg::INT_BITS;
    localparam int PR_W   = 2 * QV_W;
    localparam int QP_W   = QV_W + gfm_pkg::RCP_W;
    localparam int QK_W   = QV_W + K_W;
    localparam int SUM_W  = QV_W + 2;
    localparam int SP_W   = SW + WW;
    localparam logic [PR_W-1:0] RND_Q   = PR_W'(1) << (QF - 1);
    localparam logic [PR_W-1:0] RND_W   = PR_W'(1) << (QF - 1 - WFRAC);
    localparam logic [SP_W-1:0] RND_S   = SP_W'(1) << (WFRAC - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SER_MUL,
        ST_SER_RCP,
        ST_SER_FIX,
        ST_POW,
        ST_WMUL,
        ST_WGT,
        ST_SCALE
    } state_t;

    state_t                   state_reg, state_next;
    logic [SW-1:0]            re_reg, re_next, im_reg, im_next;
    logic                     last_reg, last_next, err_reg, err_next;
    logic [WW-1:0]            wgt_reg, wgt_next;
    logic [IB-1:0]            n_reg, n_next;
    logic [RF-1:0]            f_reg, f_next;
    logic [QV_W-1:0]          p_reg, p_next;
    logic [QV_W-1:0]          e1_reg, e1_next;
    logic                     e1_valid_reg, e1_valid_next;
    logic                     ser_e1_reg, ser_e1_next;
    logic [QV_W-1:0]          t_reg, t_next;
    logic [QV_W-1:0]          term_reg, term_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [K_W-1:0]           k_reg, k_next;
    logic [PR_W-1:0]          prod_reg, prod_next;
    logic [QV_W-1:0]          v_reg, v_next;
    logic [QV_W-1:0]          q0_reg, q0_next;
    logic [QV_W-1:0]          frac_reg, frac_next;
    logic                     out_valid_reg, out_valid_next;
    logic [SW-1:0]            real_out_reg, real_out_next;
    logic [SW-1:0]            imag_out_reg, imag_out_next;
    logic [WW-1:0]            weight_out_reg, weight_out_next;
    logic                     last_out_reg, last_out_next;
    logic                     err_out_reg, err_out_next;

    logic [QP_W-1:0]          qp;
    logic [QK_W-1:0]          qk, rem;
    logic [QV_W-1:0]          term_fix;
    logic signed [SUM_W-1:0]  sum_upd;
    logic [QV_W-1:0]          sum_pos;
    logic [PR_W-1:0]          pp, w62, h62;
    logic [WW-1:0]            hcap;
    logic                     slot_free;
    logic                     neg_re, neg_im;
    logic [SW-1:0]            mag_re, mag_im, res_re, res_im;
    logic [SP_W-1:0]          sp_re, sp_im;

    assign div_den    = gfm_pkg::R2_W'(radius) * gfm_pkg::R2_W'(radius);
    assign out_valid  = out_valid_reg;
    assign real_out   = real_out_reg;
    assign imag_out   = imag_out_reg;
    assign weight_out = weight_out_reg;
    assign last_out   = last_out_reg;
    assign err_out    = err_out_reg;
    assign slot_free  = !out_valid_reg || out_take;

    // datapath of the shared series step, the power loop, the weight rounding and the final scaling
    always_comb
    begin
        qp       = QP_W'(prod_reg[QF +: QV_W]) * QP_W'(gfm_pkg::recip(k_reg));
        qk       = QK_W'(q0_reg) * QK_W'(k_reg);
        rem      = QK_W'(v_reg) - qk;
        // reciprocal estimate is at most one short
        term_fix = (rem >= QK_W'(k_reg)) ? q0_reg + QV_W'(1) : q0_reg;
        sum_upd  = k_reg[0] ? sum_reg - SUM_W'(term_fix) : sum_reg + SUM_W'(term_fix);
        sum_pos  = sum_upd[SUM_W-1] ? '0 : QV_W'(sum_upd);
        pp       = PR_W'(p_reg) * PR_W'(e1_reg);
        w62      = (prod_reg + RND_Q) >> QF;
        h62      = (w62 + RND_W) >> (QF - WFRAC);
        hcap     = (h62 > PR_W'(gfm_pkg::WEIGHT_ONE)) ? gfm_pkg::WEIGHT_ONE : WW'(h62);
        neg_re   = re_reg[SW-1];
        neg_im   = im_reg[SW-1];
        mag_re   = neg_re ? (~re_reg + SW'(1)) : re_reg;
        mag_im   = neg_im ? (~im_reg + SW'(1)) : im_reg;
        sp_re    = SP_W'(mag_re) * SP_W'(wgt_reg);
        sp_im    = SP_W'(mag_im) * SP_W'(wgt_reg);
        res_re   = SW'((sp_re + RND_S) >> WFRAC);
        res_im   = SW'((sp_im + RND_S) >> WFRAC);
    end

    always_comb
    begin
        state_next      = state_reg;
        re_next         = re_reg;
        im_next         = im_reg;
        last_next       = last_reg;
        err_next        = err_reg;
        wgt_next        = wgt_reg;
        n_next          = n_reg;
        f_next          = f_reg;
        p_next          = p_reg;
        e1_next         = e1_reg;
        e1_valid_next   = e1_valid_reg;
        ser_e1_next     = ser_e1_reg;
        t_next          = t_reg;
        term_next       = term_reg;
        sum_next        = sum_reg;
        k_next          = k_reg;
        prod_next       = prod_reg;
        v_next          = v_reg;
        q0_next         = q0_reg;
        frac_next       = frac_reg;
        out_valid_next  = out_valid_reg && !out_take;
        real_out_next   = real_out_reg;
        imag_out_next   = imag_out_reg;
        weight_out_next = weight_out_reg;
        last_out_next   = last_out_reg;
        err_out_next    = err_out_reg;
        q_pop           = 1'b0;
        div_start       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    re_next   = q_real;
                    im_next   = q_imag;
                    last_next = q_desc.last;
                    err_next  = q_desc.err;
                    if (q_desc.err)
                    begin
                        wgt_next   = gfm_pkg::WEIGHT_ONE;
                        state_next = ST_SCALE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    n_next = div_quo[RF +: IB];
                    f_next = div_quo[RF-1:0];
                    p_next = gfm_pkg::Q_ONE;
                    if (div_ovf)
                    begin
                        wgt_next   = pass_mode ? gfm_pkg::WEIGHT_ONE : '0;
                        state_next = ST_SCALE;
                    end
                    else if (e1_valid_reg)
                    begin
                        state_next = ST_POW;
                    end
                    else
                    begin
                        // exp(-1) is worked out once after reset and kept
                        ser_e1_next = 1'b1;
                        t_next      = gfm_pkg::Q_ONE;
                        term_next   = gfm_pkg::Q_ONE;
                        sum_next    = SUM_W'(gfm_pkg::Q_ONE);
                        k_next      = K_W'(1);
                        state_next  = ST_SER_MUL;
                    end
                end
            end
            ST_SER_MUL:
            begin
                prod_next  = PR_W'(term_reg) * PR_W'(t_reg);
                state_next = ST_SER_RCP;
            end
            ST_SER_RCP:
            begin
                v_next     = prod_reg[QF +: QV_W];
                q0_next    = qp[31 +: QV_W];
                state_next = ST_SER_FIX;
            end
            ST_SER_FIX:
            begin
                term_next = term_fix;
                sum_next  = sum_upd;
                k_next    = k_reg + K_W'(1);
                if (k_reg == K_W'(gfm_pkg::TERMS))
                begin
                    if (ser_e1_reg)
                    begin
                        e1_next       = sum_pos;
                        e1_valid_next = 1'b1;
                        state_next    = ST_POW;
                    end
                    else
                    begin
                        frac_next  = sum_pos;
                        state_next = ST_WMUL;
                    end
                end
                else
                begin
                    state_next = ST_SER_MUL;
                end
            end
            ST_POW:
            begin
                if (n_reg == '0)
                begin
                    ser_e1_next = 1'b0;
                    t_next      = QV_W'({f_reg, {(QF - RF){1'b0}}});
                    term_next   = gfm_pkg::Q_ONE;
                    sum_next    = SUM_W'(gfm_pkg::Q_ONE);
                    k_next      = K_W'(1);
                    state_next  = ST_SER_MUL;
                end
                else
                begin
                    p_next = QV_W'((pp + RND_Q) >> QF);
                    n_next = n_reg - IB'(1);
                end
            end
            ST_WMUL:
            begin
                prod_next  = PR_W'(p_reg) * PR_W'(frac_reg);
                state_next = ST_WGT;
            end
            ST_WGT:
            begin
                wgt_next   = pass_mode ? (gfm_pkg::WEIGHT_ONE - hcap) : hcap;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    real_out_next   = neg_re ? (~res_re + SW'(1)) : res_re;
                    imag_out_next   = neg_im ? (~res_im + SW'(1)) : res_im;
                    weight_out_next = wgt_reg;
                    last_out_next   = last_reg;
                    err_out_next    = err_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            re_reg         <= '0;
            im_reg         <= '0;
            last_reg       <= 1'b0;
            err_reg        <= 1'b0;
            wgt_reg        <= '0;
            n_reg          <= '0;
            f_reg          <= '0;
            p_reg          <= '0;
            e1_reg         <= '0;
            e1_valid_reg   <= 1'b0;
            ser_e1_reg     <= 1'b0;
            t_reg          <= '0;
            term_reg       <= '0;
            sum_reg        <= '0;
            k_reg          <= '0;
            prod_reg       <= '0;
            v_reg          <= '0;
            q0_reg         <= '0;
            frac_reg       <= '0;
            out_valid_reg  <= 1'b0;
            real_out_reg   <= '0;
            imag_out_reg   <= '0;
            weight_out_reg <= '0;
            last_out_reg   <= 1'b0;
            err_out_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            re_reg         <= re_next;
            im_reg         <= im_next;
            last_reg       <= last_next;
            err_reg        <= err_next;
            wgt_reg        <= wgt_next;
            n_reg          <= n_next;
            f_reg          <= f_next;
            p_reg          <= p_next;
            e1_reg         <= e1_next;
            e1_valid_reg   <= e1_valid_next;
            ser_e1_reg     <= ser_e1_next;
            t_reg          <= t_next;
            term_reg       <= term_next;
            sum_reg        <= sum_next;
            k_reg          <= k_next;
            prod_reg       <= prod_next;
            v_reg          <= v_next;
            q0_reg         <= q0_next;
            frac_reg       <= frac_next;
            out_valid_reg  <= out_valid_next;
            real_out_reg   <= real_out_next;
            imag_out_reg   <= imag_out_next;
            weight_out_reg <= weight_out_next;
            last_out_reg   <= last_out_next;
            err_out_reg    <= err_out_next;
        end
    end

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_weight_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> weight_out_reg <= gfm_pkg::WEIGHT_ONE)
        else $error("weight above one");

    a_err_unity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && err_out_reg |-> weight_out_reg == gfm_pkg::WEIGHT_ONE)
        else $error("radius error transaction without unity weight");

    a_e1_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        e1_valid_reg |=> e1_valid_reg)
        else $error("cached exp(-1) lost");

endmodule

// ===== hw/rtl/gaussian_frequency_mask_core.sv =====
// Gaussian low-pass / high-pass mask for a complex spectrum in raster order.
// Input side is a queue write port: a transaction is taken when push is high
// and full is low; frame_start marks row 0, column 0. Results come out as a
// queue read port: the oldest result sits on the outputs while empty is low
// and is taken when pop is high. Configuration (frame_rows, frame_cols,
// radius, pass_mode at indexes 0..3) is written through cfg_write/cfg_index/
// cfg_data; the user must write it only while no sample is in flight, the
// block does not enforce this. A front stage tracks the raster position and
// computes the squared distance and the radius check at accept time; a
// two-entry queue feeds the back end, which divides by radius^2 bit by bit
// into a 21-bit quotient, raises exp(-1) to the integer part (one multiply
// per step, 0..31 steps), runs a 16-term series for the fraction on a shared
// multiply unit (multiply, reciprocal and fix-up states per term) and scales
// both parts. Past the table edge the weight is 0 or 1 by pass_mode. One
// sample is in the back end at a time; the next starts once the last result
// is in the output register. The first sample after reset that needs the
// exponent also waits while exp(-1) is computed. Reset restores the default
// registers and clears position and queues. A stalled reader holds the
// result; up to three more samples are still taken (one in the back end, two
// in the queue).
module gaussian_frequency_mask_core #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [SAMPLE_WIDTH-1:0]      real_in,
    input  logic [SAMPLE_WIDTH-1:0]      imag_in,
    input  logic                         frame_start,
    output logic                         empty,
    input  logic                         pop,
    output logic [SAMPLE_WIDTH-1:0]      real_out,
    output logic [SAMPLE_WIDTH-1:0]      imag_out,
    output logic [gfm_pkg::WEIGHT_W-1:0] weight,
    output logic                         last_of_frame,
    output logic                         radius_error,
    input  logic                         cfg_write,
    input  logic [1:0]                   cfg_index,
    input  logic [gfm_pkg::DIM_W-1:0]    cfg_data
);

    localparam int DIM_W  = gfm_pkg::DIM_W;
    localparam int DESC_W = $bits(gfm_pkg::desc_t);
    localparam int Q_W    = 2 * SAMPLE_WIDTH + DESC_W;

    logic [DIM_W-1:0]      frame_rows_reg, frame_cols_reg, radius_reg;
    logic                  pass_mode_reg;
    logic                  in_take, q_full, q_empty, q_pop, out_valid, out_take;
    gfm_pkg::desc_t        desc, q_desc;
    logic [Q_W-1:0]        q_wr, q_rd;
    logic                  div_start, div_done, div_ovf;
    logic [gfm_pkg::R2_W-1:0]  div_den;
    logic [gfm_pkg::QUO_W-1:0] div_quo;

    assign full     = q_full;
    assign in_take  = push && !q_full;
    assign empty    = !out_valid;
    assign out_take = pop && out_valid;
    assign q_wr     = {real_in, imag_in, desc};
    assign q_desc   = q_rd[DESC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rows_reg <= DIM_W'(512);
            frame_cols_reg <= DIM_W'(512);
            radius_reg     <= DIM_W'(30);
            pass_mode_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (gfm_pkg::cfg_idx_t'(cfg_index))
                gfm_pkg::CFG_FRAME_ROWS: frame_rows_reg <= cfg_data;
                gfm_pkg::CFG_FRAME_COLS: frame_cols_reg <= cfg_data;
                gfm_pkg::CFG_RADIUS:     radius_reg     <= cfg_data;
                gfm_pkg::CFG_PASS_MODE:  pass_mode_reg  <= cfg_data[0];
                default:                 pass_mode_reg  <= pass_mode_reg;
            endcase
        end
    end

    gfm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_take),
        .frame_start (frame_start),
        .frame_rows  (frame_rows_reg),
        .frame_cols  (frame_cols_reg),
        .radius      (radius_reg),
        .desc        (desc)
    );

    gfm_fifo #(
        .DATA_W (Q_W)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (in_take),
        .wr_data (q_wr),
        .pop     (q_pop),
        .rd_data (q_rd),
        .full    (q_full),
        .empty   (q_empty)
    );

    gfm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (q_desc.dist2),
        .divisor  (div_den),
        .done     (div_done),
        .overflow (div_ovf),
        .quotient (div_quo)
    );

    gfm_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_real     (q_rd[Q_W-1 -: SAMPLE_WIDTH]),
        .q_imag     (q_rd[DESC_W +: SAMPLE_WIDTH]),
        .q_desc     (q_desc),
        .q_pop      (q_pop),
        .radius     (radius_reg),
        .pass_mode  (pass_mode_reg),
        .div_start  (div_start),
        .div_den    (div_den),
        .div_done   (div_done),
        .div_ovf    (div_ovf),
        .div_quo    (div_quo),
        .out_take   (out_take),
        .out_valid  (out_valid),
        .real_out   (real_out),
        .imag_out   (imag_out),
        .weight_out (weight),
        .last_out   (last_of_frame),
        .err_out    (radius_error)
    );

endmodule
